// ----- rtl/ame_pkg.sv -----
// ame_pkg: shared constants for the accumulator machine execute block
// opcode codes, field widths and default memory depth; no dependencies
`default_nettype none
package ame_pkg;

  localparam int unsigned XLEN       = 32;
  localparam int unsigned LINE_W     = 16;
  localparam int unsigned OP_W       = 5;
  localparam int unsigned DEPTH_DEF  = 1024;

  typedef logic [XLEN-1:0]   word_t;
  typedef logic [LINE_W-1:0] line_t;
  typedef logic [OP_W-1:0]   opcode_t;

  localparam opcode_t OP_NOP       = 5'd0;
  localparam opcode_t OP_STORE     = 5'd1;
  localparam opcode_t OP_STORE_IND = 5'd2;
  localparam opcode_t OP_LOAD      = 5'd3;
  localparam opcode_t OP_LOAD_IMM  = 5'd4;
  localparam opcode_t OP_LOAD_IND  = 5'd5;
  localparam opcode_t OP_WRITE     = 5'd6;
  localparam opcode_t OP_READ      = 5'd7;
  localparam opcode_t OP_ADD       = 5'd8;
  localparam opcode_t OP_ADD_IMM   = 5'd9;
  localparam opcode_t OP_SUB       = 5'd10;
  localparam opcode_t OP_SUB_IMM   = 5'd11;
  localparam opcode_t OP_MUL       = 5'd12;
  localparam opcode_t OP_MUL_IMM   = 5'd13;
  localparam opcode_t OP_DIV       = 5'd14;
  localparam opcode_t OP_DIV_IMM   = 5'd15;
  localparam opcode_t OP_END       = 5'd16;
  localparam opcode_t OP_BR        = 5'd17;
  localparam opcode_t OP_BEQ       = 5'd18;
  localparam opcode_t OP_BGE       = 5'd19;
  localparam opcode_t OP_BGT       = 5'd20;
  localparam opcode_t OP_BLE       = 5'd21;
  localparam opcode_t OP_BLT       = 5'd22;

endpackage
`default_nettype wire

// ----- rtl/ame_if.sv -----
// ame_if: valid/ready channels for instruction items and result items
// depends on ame_pkg for field types
`default_nettype none
interface ame_in_if;
  import ame_pkg::*;
  logic    valid;
  logic    ready;
  opcode_t op;
  word_t   operand;
  word_t   read_value;
  modport source (output valid, output op, output operand, output read_value, input ready);
  modport sink   (input valid, input op, input operand, input read_value, output ready);
endinterface

interface ame_out_if;
  import ame_pkg::*;
  logic  valid;
  logic  ready;
  line_t next_line;
  logic  halted;
  logic  out_valid;
  word_t out_value;
  word_t acc_value;
  modport source (output valid, output next_line, output halted, output out_valid,
                  output out_value, output acc_value, input ready);
  modport sink   (input valid, input next_line, input halted, input out_valid,
                  input out_value, input acc_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/accumulator_machine_execute.sv -----
// accumulator_machine_execute: one accumulator-machine instruction per item
// sequence: address reduction and memory read or write for memory operands, repeated for the
// indirect cell value, then execute, then ame_div for divides, which ends early on a zero divisor
// throughput: one item at a time; next item taken once the result is registered
// reset: accumulator 0, line 1, then a clearing pass over every cell of the data
// memory during which no item is taken; depends on ame_pkg, ame_if, ame_mem, ame_amod, ame_div
`default_nettype none
module accumulator_machine_execute #(
  parameter int unsigned DATA_DEPTH = ame_pkg::DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ame_in_if.sink     in_i,
  ame_out_if.source  out_o
);
  import ame_pkg::*;

  localparam int unsigned ADDR_W = $clog2(DATA_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_ADDR, S_RD, S_EXEC, S_DIV, S_DONE
  } state_e;

  state_e  state_q;
  opcode_t op_q;
  word_t   opr_q;
  word_t   rv_q;
  logic    ind_q;
  word_t   mem_q;
  word_t   acc_q;
  line_t   line_q;
  word_t   res_acc_q;
  line_t   res_line_q;
  logic    res_halt_q;
  logic    res_wv_q;
  word_t   res_wval_q;
  logic    ov_q;

  logic              accept;
  logic              needs_mem;
  logic              amod_start;
  word_t             amod_value;
  logic              amod_done;
  logic [ADDR_W-1:0] amod_addr;
  logic              mem_we;
  logic              mem_re;
  word_t             mem_rdata;
  logic              clr_busy;
  logic              is_ind;
  logic              div_start;
  logic              div_done;
  word_t             div_quot;
  logic              out_free;
  word_t             src;
  word_t             prod;
  logic              jump;
  logic              acc_neg;
  logic              acc_zero;

  // handshake
  assign in_i.ready = (state_q == S_IDLE) && !clr_busy;
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !ov_q || out_o.ready;

  always_comb begin
    case (in_i.op)
      OP_STORE, OP_STORE_IND, OP_LOAD, OP_LOAD_IND,
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: needs_mem = 1'b1;
      default:                        needs_mem = 1'b0;
    endcase
  end

  assign is_ind = (op_q == OP_STORE_IND) || (op_q == OP_LOAD_IND);

  // address reduction requests: operand first, cell value for indirect forms
  assign amod_start = (accept && needs_mem) || (state_q == S_RD && is_ind && !ind_q);
  assign amod_value = (state_q == S_RD) ? mem_rdata : in_i.operand;

  // memory port control
  assign mem_we = (state_q == S_ADDR) && amod_done &&
                  ((op_q == OP_STORE) || (op_q == OP_STORE_IND && ind_q));
  assign mem_re = (state_q == S_ADDR) && amod_done && !mem_we;

  ame_amod #(.DATA_DEPTH(DATA_DEPTH), .ADDR_W(ADDR_W)) u_amod (
    .clk_i, .rst_ni,
    .start_i (amod_start),
    .value_i (amod_value),
    .done_o  (amod_done),
    .addr_o  (amod_addr)
  );

  ame_mem #(.DATA_DEPTH(DATA_DEPTH), .ADDR_W(ADDR_W)) u_mem (
    .clk_i, .rst_ni,
    .we_i       (mem_we),
    .re_i       (mem_re),
    .addr_i     (amod_addr),
    .wdata_i    (acc_q),
    .rdata_o    (mem_rdata),
    .clr_busy_o (clr_busy)
  );

  // operand source and arithmetic
  always_comb begin
    case (op_q)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: src = mem_q;
      default:                        src = opr_q;
    endcase
  end

  assign prod      = acc_q * src;
  assign div_start = (state_q == S_EXEC) && ((op_q == OP_DIV) || (op_q == OP_DIV_IMM));

  ame_div u_div (
    .clk_i, .rst_ni,
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (src),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // branch conditions
  assign acc_neg  = acc_q[XLEN-1];
  assign acc_zero = (acc_q == '0);

  always_comb begin
    case (op_q)
      OP_BR:   jump = 1'b1;
      OP_BEQ:  jump = acc_zero;
      OP_BGE:  jump = !acc_neg;
      OP_BGT:  jump = !acc_neg && !acc_zero;
      OP_BLE:  jump = acc_neg || acc_zero;
      OP_BLT:  jump = acc_neg;
      default: jump = 1'b0;
    endcase
  end

  // sequencer with machine state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ind_q   <= 1'b0;
      acc_q   <= '0;
      line_q  <= LINE_W'(1);
      ov_q    <= 1'b0;
    end else begin
      if (ov_q && out_o.ready && state_q != S_DONE) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q    <= in_i.op;
            opr_q   <= in_i.operand;
            rv_q    <= in_i.read_value;
            ind_q   <= 1'b0;
            state_q <= needs_mem ? S_ADDR : S_EXEC;
          end
        end
        S_ADDR: begin
          if (amod_done) state_q <= mem_we ? S_EXEC : S_RD;
        end
        S_RD: begin
          mem_q <= mem_rdata;
          if (is_ind && !ind_q) begin
            ind_q   <= 1'b1;
            state_q <= S_ADDR;
          end else begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_halt_q <= (op_q == OP_END);
          res_wv_q   <= (op_q == OP_WRITE);
          res_wval_q <= '0;
          if (op_q == OP_END)  res_line_q <= '0;
          else if (jump)       res_line_q <= opr_q[LINE_W-1:0];
          else                 res_line_q <= line_q + 1'b1;
          res_acc_q <= acc_q;
          case (op_q)
            OP_LOAD, OP_LOAD_IND: res_acc_q <= mem_q;
            OP_LOAD_IMM:          res_acc_q <= opr_q;
            OP_WRITE:             res_wval_q <= (opr_q != '0) ? opr_q : acc_q;
            OP_READ:              res_acc_q <= (opr_q != '0) ? opr_q : rv_q;
            OP_ADD, OP_ADD_IMM:   res_acc_q <= acc_q + src;
            OP_SUB, OP_SUB_IMM:   res_acc_q <= acc_q - src;
            OP_MUL, OP_MUL_IMM:   res_acc_q <= prod;
            default:              ;
          endcase
          state_q <= div_start ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (div_done) begin
            res_acc_q <= div_quot;
            state_q   <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            ov_q              <= 1'b1;
            out_o.next_line   <= res_line_q;
            out_o.halted      <= res_halt_q;
            out_o.out_valid   <= res_wv_q;
            out_o.out_value   <= res_wval_q;
            out_o.acc_value   <= res_acc_q;
            acc_q             <= res_acc_q;
            line_q            <= res_line_q;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid = ov_q;
endmodule
`default_nettype wire

// ----- rtl/ame_mem.sv -----
// ame_mem: data memory, one write and one registered read port
// clears every cell after reset, one cell a cycle; depends on ame_pkg
`default_nettype none
module ame_mem #(
  parameter int unsigned DATA_DEPTH = ame_pkg::DEPTH_DEF,
  parameter int unsigned ADDR_W     = $clog2(DATA_DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              we_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire ame_pkg::word_t    wdata_i,
  output ame_pkg::word_t         rdata_o,
  output logic                   clr_busy_o
);
  import ame_pkg::*;

  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DATA_DEPTH - 1);

  word_t             mem [DATA_DEPTH];
  logic              clr_q;
  logic [ADDR_W-1:0] clr_cnt_q;

  // clearing pass sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == LAST) clr_q <= 1'b0;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) rdata_o <= mem[addr_i];
  end

  assign clr_busy_o = clr_q;
endmodule
`default_nettype wire

// ----- rtl/ame_amod.sv -----
// ame_amod: reduces a 32-bit value modulo the memory depth
// mask for a power-of-two depth, else a registered reciprocal multiply; depends on ame_pkg
`default_nettype none
module ame_amod #(
  parameter int unsigned DATA_DEPTH = ame_pkg::DEPTH_DEF,
  parameter int unsigned ADDR_W     = $clog2(DATA_DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire ame_pkg::word_t    value_i,
  output logic                   done_o,
  output logic [ADDR_W-1:0]      addr_o
);
  import ame_pkg::*;

  if ((DATA_DEPTH & (DATA_DEPTH - 1)) == 0) begin : g_pow2
    // low bits only
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) done_o <= 1'b0;
      else         done_o <= start_i;
    end
    always_ff @(posedge clk_i) begin
      if (start_i) addr_o <= value_i[ADDR_W-1:0];
    end
  end else begin : g_recip
    // quotient = (value * ceil(2^(32+ADDR_W) / depth)) >> (32+ADDR_W), exact for 32-bit values
    localparam logic [XLEN:0] MULT =
      (XLEN+1)'(((64'd1 << (XLEN + ADDR_W)) / DATA_DEPTH) + 64'd1);
    localparam word_t DEP = word_t'(DATA_DEPTH);

    logic              s1_q;
    logic              s2_q;
    word_t             v_q;
    logic [2*XLEN:0]   prod_q;
    logic [ADDR_W-1:0] addr_q;
    word_t             quo;
    word_t             rem;

    assign quo = word_t'(prod_q >> (XLEN + ADDR_W));
    assign rem = v_q - quo * DEP;

    // stage valid bits
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s1_q   <= 1'b0;
        s2_q   <= 1'b0;
        done_o <= 1'b0;
      end else begin
        s1_q   <= start_i;
        s2_q   <= s1_q;
        done_o <= s2_q;
      end
    end

    // value, product, remainder
    always_ff @(posedge clk_i) begin
      if (start_i) v_q <= value_i;
      if (s1_q)    prod_q <= {{(XLEN+1){1'b0}}, v_q} * {{XLEN{1'b0}}, MULT};
      if (s2_q)    addr_q <= rem[ADDR_W-1:0];
    end

    assign addr_o = addr_q;
  end
endmodule
`default_nettype wire

// ----- rtl/ame_div.sv -----
// ame_div: signed 32-bit division truncating toward zero, one bit a cycle
// zero divisor returns the dividend; depends on ame_pkg
`default_nettype none
module ame_div (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire ame_pkg::word_t dividend_i,
  input  wire ame_pkg::word_t divisor_i,
  output logic                done_o,
  output ame_pkg::word_t      quot_o
);
  import ame_pkg::*;

  logic          busy_q;
  logic [4:0]    cnt_q;
  logic          neg_q;
  logic          zero_q;
  word_t         quo_q;
  word_t         mb_q;
  word_t         a_q;
  logic [XLEN:0] rem_q;
  logic [XLEN:0] shifted;
  logic [XLEN:0] diff;
  logic          na;
  logic          nb;

  assign na = dividend_i[XLEN-1];
  assign nb = divisor_i[XLEN-1];

  // restoring step
  assign shifted = {rem_q[XLEN-1:0], quo_q[XLEN-1]};
  assign diff    = shifted - {1'b0, mb_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (zero_q || cnt_q == 5'(XLEN - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= dividend_i;
      neg_q  <= na ^ nb;
      zero_q <= (divisor_i == '0);
      quo_q  <= na ? (~dividend_i + 1'b1) : dividend_i;
      mb_q   <= nb ? (~divisor_i + 1'b1) : divisor_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      if (!diff[XLEN]) begin
        rem_q <= diff;
        quo_q <= {quo_q[XLEN-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[XLEN-2:0], 1'b0};
      end
    end
  end

  assign quot_o = zero_q ? a_q : (neg_q ? (~quo_q + 1'b1) : quo_q);
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// tb: self-checking bench for accumulator_machine_execute
// drives instruction items and checks every result item against a local machine model
// depends on ame_pkg, ame_if and the block's rtl
`timescale 1ns / 100ps

typedef struct {
  ame_pkg::line_t next_line;
  logic           halted;
  logic           out_valid;
  ame_pkg::word_t out_value;
  ame_pkg::word_t acc_value;
} result_t;

class ame_scoreboard;
  ame_pkg::word_t acc;
  ame_pkg::word_t mem[1024];
  ame_pkg::line_t line;
  result_t        expected_q[$];
  int             mismatches;

  function new();
    acc = '0;
    line = 16'd1;
    foreach (mem[i]) mem[i] = '0;
    mismatches = 0;
  endfunction

  // signed division truncating toward zero, zero divisor keeps the dividend
  function ame_pkg::word_t quotient(ame_pkg::word_t a, ame_pkg::word_t b);
    ame_pkg::word_t ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    if (mb == 0) return a;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // execute one instruction item on the local machine state
  function void note_instruction(ame_pkg::opcode_t op, ame_pkg::word_t opr,
                                 ame_pkg::word_t rv);
    import ame_pkg::*;
    result_t r;
    logic    jump, neg, zero;
    neg = acc[31];
    zero = (acc == 0);
    jump = 1'b0;
    r.halted = 1'b0;
    r.out_valid = 1'b0;
    r.out_value = '0;
    case (op)
      OP_STORE:     mem[opr[9:0]] = acc;
      OP_STORE_IND: mem[mem[opr[9:0]][9:0]] = acc;
      OP_LOAD:      acc = mem[opr[9:0]];
      OP_LOAD_IMM:  acc = opr;
      OP_LOAD_IND:  acc = mem[mem[opr[9:0]][9:0]];
      OP_WRITE: begin
        r.out_valid = 1'b1;
        r.out_value = (opr != 0) ? opr : acc;
      end
      OP_READ:      acc = (opr != 0) ? opr : rv;
      OP_ADD:       acc = acc + mem[opr[9:0]];
      OP_ADD_IMM:   acc = acc + opr;
      OP_SUB:       acc = acc - mem[opr[9:0]];
      OP_SUB_IMM:   acc = acc - opr;
      OP_MUL:       acc = acc * mem[opr[9:0]];
      OP_MUL_IMM:   acc = acc * opr;
      OP_DIV:       acc = quotient(acc, mem[opr[9:0]]);
      OP_DIV_IMM:   acc = quotient(acc, opr);
      OP_END:       r.halted = 1'b1;
      OP_BR:        jump = 1'b1;
      OP_BEQ:       jump = zero;
      OP_BGE:       jump = !neg;
      OP_BGT:       jump = !neg && !zero;
      OP_BLE:       jump = neg || zero;
      OP_BLT:       jump = neg;
      default: ;
    endcase
    if (r.halted) line = '0;
    else if (jump) line = opr[15:0];
    else line = line + 16'd1;
    r.next_line = line;
    r.acc_value = acc;
    expected_q.push_back(r);
  endfunction

  // compare one result item with the oldest expectation
  function void check_result(result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result item: next_line %0d acc %h",
                                     got.next_line, got.acc_value);
      return;
    end
    want = expected_q.pop_front();
    if (got.next_line !== want.next_line || got.halted !== want.halted ||
        got.out_valid !== want.out_valid || got.out_value !== want.out_value ||
        got.acc_value !== want.acc_value) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp line %0d halt %b wv %b wval %h acc %h / got %0d %b %b %h %h",
                 want.next_line, want.halted, want.out_valid, want.out_value,
                 want.acc_value, got.next_line, got.halted, got.out_valid,
                 got.out_value, got.acc_value);
    end
  endfunction
endclass

module tb;
  import ame_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  logic hold_request = 1'b0;
  int   hold_left = 0;

  ame_in_if  in_if();
  ame_out_if out_if();
  ame_scoreboard machine;

  accumulator_machine_execute dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // timeout guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.next_line = out_if.next_line;
      got.halted = out_if.halted;
      got.out_valid = out_if.out_valid;
      got.out_value = out_if.out_value;
      got.acc_value = out_if.acc_value;
      machine.check_result(got);
    end
  end

  // offer one instruction item and wait until it is taken
  task automatic send_instruction(opcode_t op, word_t opr, word_t rv);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.operand <= opr;
    in_if.read_value <= rv;
    do @(posedge clk_i); while (!in_if.ready);
    machine.note_instruction(op, opr, rv);
  endtask

  // operand mix: mostly valid addresses, some small values and extremes
  function automatic word_t pick_operand();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return word_t'($urandom_range(1023));
      6:       return $urandom();
      7:       return word_t'($urandom_range(40)) - 32'd20;
      8:       return ($urandom_range(1)) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return word_t'($urandom_range(65535));
    endcase
  endfunction

  initial begin
    opcode_t op;
    machine = new();
    in_if.valid = 1'b0;
    in_if.op = OP_NOP;
    in_if.operand = '0;
    in_if.read_value = '0;
    out_if.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: every operation, extremes and corner cases
    send_instruction(OP_WRITE, 32'd0, 32'd0);
    send_instruction(OP_LOAD_IMM, 32'h8000_0000, 32'hffff_ffff);
    send_instruction(OP_DIV_IMM, 32'hffff_ffff, 32'd0);        // overflowing divide
    send_instruction(OP_BLT, 32'hffff_ffff, 32'd0);            // taken, line 65535
    send_instruction(OP_NOP, 32'd0, 32'd0);                    // line wraps to 0
    send_instruction(OP_STORE, 32'd5, 32'd0);
    send_instruction(OP_DIV, 32'd6, 32'd0);                    // zero divisor
    send_instruction(OP_READ, 32'd0, 32'h7fff_ffff);
    send_instruction(OP_READ, 32'd3, 32'h1234_5678);
    send_instruction(OP_STORE, 32'hffff_fc07, 32'd0);          // address from low bits
    send_instruction(OP_LOAD_IMM, 32'd7, 32'd0);
    send_instruction(OP_STORE, 32'd1023, 32'd0);
    send_instruction(OP_STORE_IND, 32'd1023, 32'd0);
    send_instruction(OP_LOAD_IND, 32'd1023, 32'd0);
    send_instruction(OP_LOAD, 32'd5, 32'd0);
    send_instruction(OP_ADD, 32'd7, 32'd0);
    send_instruction(OP_ADD_IMM, 32'h7fff_ffff, 32'd0);
    send_instruction(OP_SUB, 32'd7, 32'd0);
    send_instruction(OP_SUB_IMM, 32'h8000_0000, 32'd0);
    send_instruction(OP_MUL, 32'd1023, 32'd0);
    send_instruction(OP_MUL_IMM, 32'hffff_fffd, 32'd0);
    send_instruction(OP_WRITE, 32'hdead_beef, 32'd0);
    send_instruction(OP_END, 32'd9, 32'd0);
    send_instruction(OP_BR, 32'h0001_ffff, 32'd0);
    send_instruction(OP_BEQ, 32'd3, 32'd0);
    send_instruction(OP_BGE, 32'd4, 32'd0);
    send_instruction(OP_BGT, 32'd8, 32'd0);
    send_instruction(OP_BLE, 32'd2, 32'd0);
    send_instruction(opcode_t'(31), 32'd1, 32'd0);
    send_instruction(opcode_t'(23), 32'd1, 32'd0);

    // random phases: none, sender idle, receiver stall, both
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1) ? 62 : (phase == 3) ? 16 : 0;
      stall_pct = (phase == 2) ? 62 : (phase == 3) ? 16 : 0;
      if (phase == 0) hold_request = 1'b1;
      for (int n = 0; n < 480; n++) begin
        if ($urandom_range(9) == 0) op = opcode_t'($urandom_range(31));
        else op = opcode_t'($urandom_range(22));
        send_instruction(op, pick_operand(), $urandom());
      end
    end
    in_if.valid <= 1'b0;

    // drain
    while (machine.expected_q.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (machine.mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
